// ----- rtl/core/hdic_pkg.sv -----
// ----------------------------------------------------------------------------
// hdic_pkg
// Shared types, constants and functions of the decoded instruction cache.
// ----------------------------------------------------------------------------
package hdic_pkg;

    localparam int unsigned ENTRIES  = 1024;
    localparam int unsigned IDX_W    = $clog2(ENTRIES);
    localparam int unsigned QDEPTH   = 2;

    localparam logic [31:0] MIX_C1   = 32'h85ebca6b;
    localparam logic [31:0] MIX_C2   = 32'hc2b2ae35;

    typedef enum logic [1:0] {
        FN_LOOKUP  = 2'd0,
        FN_FILL    = 2'd1,
        FN_INVAL   = 2'd2,
        FN_PREDICT = 2'd3
    } t_func;

    localparam logic [0:0] CFG_HOT_THRESHOLD  = 1'b0;
    localparam logic [0:0] CFG_PREDICT_ENABLE = 1'b1;

    localparam int unsigned FL_CALL = 0;
    localparam int unsigned FL_RET  = 1;
    localparam int unsigned FL_JUMP = 2;
    localparam int unsigned FL_MOV  = 3;
    localparam int unsigned FL_ADD  = 4;
    localparam int unsigned FL_HOT  = 5;

    // request passed from front to back
    typedef struct packed {
        t_func             func;
        logic [31:0]       address;
        logic [31:0]       opcode;
        logic [31:0]       arg_first;
        logic [31:0]       arg_second;
        logic [IDX_W-1:0]  idx;
        logic [5:0]        fill_flags;
        logic [2:0]        fill_length;
    } t_req;

    typedef struct packed {
        logic        hit;
        logic [31:0] hit_opcode;
        logic [31:0] hit_arg_first;
        logic [31:0] hit_arg_second;
        logic [2:0]  hit_length;
        logic [5:0]  hit_flags;
        logic [31:0] hit_uses;
        logic [31:0] next_address;
        logic        next_valid;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } t_res;

    function automatic logic [5:0] classify(input logic [7:0] op);
        logic [5:0] f;
        f = '0;
        unique case (op)
            8'hE8, 8'hFF:                         f[FL_CALL] = 1'b1;
            8'hC3, 8'hC2, 8'hCA:                  f[FL_RET]  = 1'b1;
            8'h74, 8'h75, 8'h7E, 8'h7F,
            8'hEB, 8'hE9, 8'hEA:                  f[FL_JUMP] = 1'b1;
            8'h88, 8'h89:                         f[FL_MOV]  = 1'b1;
            8'h00, 8'h01, 8'h02, 8'h03,
            8'h04, 8'h05, 8'h28, 8'h29:           f[FL_ADD]  = 1'b1;
            default:                              f = '0;
        endcase
        return f;
    endfunction

    function automatic logic [2:0] length_of(input logic [7:0] p);
        logic [2:0] l;
        if (p >= 8'h88 && p <= 8'h8B)      l = 3'd2;
        else if (p >= 8'hB8 && p <= 8'hBF) l = 3'd5;
        else if (p == 8'hE8 || p == 8'hE9) l = 3'd5;
        else if (p == 8'hEB)               l = 3'd2;
        else                               l = 3'd1;
        return l;
    endfunction

endpackage

// ----- rtl/core/hashed_decoded_instruction_cache_unit.sv -----
// ----------------------------------------------------------------------------
// hashed_decoded_instruction_cache_unit
// Direct-mapped decoded instruction cache indexed by a hashed address.
// ----------------------------------------------------------------------------
// channel | ports                                   | handshake
// request | i_func i_address i_opcode i_arg_*       | i_push / o_full
// result  | o_hit o_hit_* o_next_* o_*_total        | o_empty / i_pop
// config  | i_cfg_idx i_cfg_data                    | i_cfg_we
//
// The back end reads, then updates, the entry memory for a request before it takes the next.
// Hashing runs in registered multiply stages ahead of a two-deep request queue.
// After reset a clearing pass over all 1024 entries runs before requests are served.
// A full result register stalls the back end; the queue then fills.
// ----------------------------------------------------------------------------
module hashed_decoded_instruction_cache_unit import hdic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_address,
    input  logic [31:0] i_opcode,
    input  logic [31:0] i_arg_first,
    input  logic [31:0] i_arg_second,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_hit,
    output logic [31:0] o_hit_opcode,
    output logic [31:0] o_hit_arg_first,
    output logic [31:0] o_hit_arg_second,
    output logic [2:0]  o_hit_length,
    output logic [5:0]  o_hit_flags,
    output logic [31:0] o_hit_uses,
    output logic [31:0] o_next_address,
    output logic        o_next_valid,
    output logic [31:0] o_hit_total,
    output logic [31:0] o_miss_total
);

    logic w_q_valid, w_q_pop;
    t_req w_q_req;
    t_res w_res;

    hdic_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_func, .i_address, .i_opcode,
        .i_arg_first, .i_arg_second,
        .o_q_valid (w_q_valid), .o_q_req (w_q_req), .i_q_pop (w_q_pop)
    );

    hdic_back u_back (
        .i_clk, .i_rst_n,
        .i_q_valid (w_q_valid), .i_q_req (w_q_req), .o_q_pop (w_q_pop),
        .i_cfg_we, .i_cfg_idx, .i_cfg_data, .o_empty, .i_pop,
        .o_res (w_res)
    );

    assign o_hit            = w_res.hit;
    assign o_hit_opcode     = w_res.hit_opcode;
    assign o_hit_arg_first  = w_res.hit_arg_first;
    assign o_hit_arg_second = w_res.hit_arg_second;
    assign o_hit_length     = w_res.hit_length;
    assign o_hit_flags      = w_res.hit_flags;
    assign o_hit_uses       = w_res.hit_uses;
    assign o_next_address   = w_res.next_address;
    assign o_next_valid     = w_res.next_valid;
    assign o_hit_total      = w_res.hit_total;
    assign o_miss_total     = w_res.miss_total;

endmodule

// ----- rtl/core/hdic_front.sv -----
// ----------------------------------------------------------------------------
// hdic_front
// Accepts requests, hashes the address in two multiply stages, classifies
// the opcode and pushes the request into the decoupling queue.
// ----------------------------------------------------------------------------
module hdic_front import hdic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [1:0]  i_func,
    input  logic [31:0] i_address,
    input  logic [31:0] i_opcode,
    input  logic [31:0] i_arg_first,
    input  logic [31:0] i_arg_second,
    output logic        o_q_valid,
    output t_req        o_q_req,
    input  logic        i_q_pop
);

    // stage 1: first multiply, stage 2: second multiply and mask
    logic        r_s1_v, r_s2_v;
    t_req        r_s1_req, r_s2_req;
    logic [31:0] r_s1_mix, r_s2_mix;
    logic [31:0] w_h0, w_h1, w_h2;

    t_req                    r_q_mem [QDEPTH];
    logic [$clog2(QDEPTH):0] r_q_cnt;
    logic [$clog2(QDEPTH)-1:0] r_q_rd, r_q_wr;

    logic w_s2_adv, w_s1_adv, w_in_acc;
    // count items in flight so nothing enters the pipe without a queue slot
    logic [2:0] r_inflight;
    logic [2:0] n_inflight;
    t_req       w_new;
    t_req       w_q_in;

    assign w_h0 = i_address ^ (i_address >> 16);
    assign w_h1 = r_s1_mix ^ (r_s1_mix >> 13);
    assign w_h2 = r_s2_mix ^ (r_s2_mix >> 16);

    assign o_full   = ({1'b0, r_inflight} + 4'(r_q_cnt)) >= 4'(QDEPTH);
    assign w_in_acc = i_push && !o_full;
    assign w_s2_adv = r_s2_v;
    assign w_s1_adv = r_s1_v;

    always_comb begin
        w_new             = '0;
        w_new.func        = t_func'(i_func);
        w_new.address     = i_address;
        w_new.opcode      = i_opcode;
        w_new.arg_first   = i_arg_first;
        w_new.arg_second  = i_arg_second;
        w_new.fill_flags  = classify(i_opcode[7:0]);
        w_new.fill_length = length_of(i_opcode[23:16]);
    end

    always_comb begin
        w_q_in     = r_s2_req;
        w_q_in.idx = w_h2[IDX_W-1:0];
    end

    always_comb begin
        n_inflight = r_inflight;
        if (w_in_acc) n_inflight = n_inflight + 3'd1;
        if (w_s2_adv) n_inflight = n_inflight - 3'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v     <= 1'b0;
            r_s2_v     <= 1'b0;
            r_inflight <= '0;
        end else begin
            r_s1_v     <= w_in_acc;
            r_s2_v     <= w_s1_adv;
            r_inflight <= n_inflight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_s1_req <= w_new;
            r_s1_mix <= w_h0 * MIX_C1;
        end
        if (w_s1_adv) begin
            r_s2_req <= r_s1_req;
            r_s2_mix <= w_h1 * MIX_C2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= '0;
            r_q_rd  <= '0;
            r_q_wr  <= '0;
        end else begin
            if (w_s2_adv) r_q_wr <= r_q_wr + 1'b1;
            if (i_q_pop)  r_q_rd <= r_q_rd + 1'b1;
            r_q_cnt <= r_q_cnt + (w_s2_adv ? 1'b1 : 1'b0) - (i_q_pop ? 1'b1 : 1'b0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_adv) begin
            r_q_mem[r_q_wr] <= w_q_in;
        end
    end

    assign o_q_valid = r_q_cnt != '0;
    assign o_q_req   = r_q_mem[r_q_rd];

endmodule

// ----- rtl/core/hdic_back.sv -----
// ----------------------------------------------------------------------------
// hdic_back
// Entry memory read-modify-write: read cycle, then update and result cycle.
// A clearing pass after reset invalidates every entry.
// ----------------------------------------------------------------------------
module hdic_back import hdic_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_req        i_q_req,
    output logic        o_q_pop,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output logic        o_empty,
    input  logic        i_pop,
    output t_res        o_res
);

    typedef enum logic [2:0] {
        ST_CLEAR = 3'b001,
        ST_READ  = 3'b010,
        ST_EXEC  = 3'b100
    } t_state;

    // entry: valid, tag, opcode, a1, a2, length, flags, uses
    typedef struct packed {
        logic        valid;
        logic [31:0] tag;
        logic [31:0] opcode;
        logic [31:0] arg_first;
        logic [31:0] arg_second;
        logic [2:0]  length;
        logic [5:0]  flags;
        logic [31:0] uses;
    } t_entry;

    t_entry r_mem [ENTRIES];
    t_entry r_rd;
    t_state r_state, n_state;
    t_req   r_req;
    logic [IDX_W-1:0] r_clr;
    logic [31:0] r_thr;
    logic        r_pen;
    logic [31:0] r_hits, r_miss;
    logic        r_out_v;
    t_res        r_out;

    logic   w_match, w_look, w_we, w_hot, w_cnt_hit, w_cnt_miss;
    t_entry w_upd, w_wr;
    t_res   w_res;

    assign o_empty = !r_out_v;
    assign o_res   = r_out;
    assign o_q_pop = (r_state == ST_READ) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= 32'd16;
            r_pen <= 1'b1;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_HOT_THRESHOLD) r_thr <= i_cfg_data;
            else                                r_pen <= i_cfg_data[0];
        end
    end

    assign w_match = r_rd.valid && (r_rd.tag == r_req.address);
    assign w_look  = (r_req.func == FN_LOOKUP) || (r_req.func == FN_FILL)
                  || ((r_req.func == FN_PREDICT) && r_pen);
    assign w_cnt_hit  = w_look && w_match;
    assign w_cnt_miss = w_look && !w_match;

    always_comb begin
        w_upd = r_rd;
        if (w_cnt_hit) begin
            w_upd.uses = r_rd.uses + 32'd1;
            if (w_upd.uses >= r_thr) w_upd.flags[FL_HOT] = 1'b1;
        end
        w_hot = w_cnt_hit && w_upd.flags[FL_HOT];
        w_wr  = w_upd;
        w_we  = w_cnt_hit;
        unique case (r_req.func)
            FN_FILL: begin
                if (w_hot || (w_upd.uses < r_thr)) begin
                    w_wr.valid      = 1'b1;
                    w_wr.tag        = r_req.address;
                    w_wr.opcode     = r_req.opcode;
                    w_wr.arg_first  = r_req.arg_first;
                    w_wr.arg_second = r_req.arg_second;
                    w_wr.length     = r_req.fill_length;
                    w_wr.flags      = r_req.fill_flags | (w_hot ? 6'h20 : 6'h00);
                    w_wr.uses       = 32'd1;
                    w_we            = 1'b1;
                end
            end
            FN_INVAL: begin
                if (w_match) begin
                    w_wr.valid = 1'b0;
                    w_wr.tag   = '1;
                    w_we       = 1'b1;
                end
            end
            default: ;
        endcase

        w_res = '0;
        if (w_cnt_hit) begin
            w_res.hit            = 1'b1;
            w_res.hit_opcode     = r_rd.opcode;
            w_res.hit_arg_first  = r_rd.arg_first;
            w_res.hit_arg_second = r_rd.arg_second;
            w_res.hit_length     = r_rd.length;
            w_res.hit_flags      = w_upd.flags;
            w_res.hit_uses       = w_upd.uses;
            if ((r_req.func == FN_PREDICT) && !r_rd.flags[FL_JUMP]) begin
                w_res.next_address = r_req.address + {29'd0, r_rd.length};
                w_res.next_valid   = 1'b1;
            end
        end
        w_res.hit_total  = r_hits + (w_cnt_hit ? 32'd1 : 32'd0);
        w_res.miss_total = r_miss + (w_cnt_miss ? 32'd1 : 32'd0);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == IDX_W'(ENTRIES - 1)) n_state = ST_READ;
            ST_READ:  if (i_q_valid) n_state = ST_EXEC;
            ST_EXEC:  if (!r_out_v || i_pop) n_state = ST_READ;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_hits  <= '0;
            r_miss  <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if ((r_state == ST_EXEC) && (!r_out_v || i_pop)) begin
                r_hits  <= w_res.hit_total;
                r_miss  <= w_res.miss_total;
                r_out_v <= 1'b1;
            end else if (i_pop) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CLEAR) begin
            r_mem[r_clr] <= '{valid: 1'b0, tag: '1, default: '0};
        end else if ((r_state == ST_EXEC) && (!r_out_v || i_pop) && w_we) begin
            r_mem[r_req.idx] <= w_wr;
        end
        if (o_q_pop) begin
            r_req <= i_q_req;
            r_rd  <= r_mem[i_q_req.idx];
        end
        if ((r_state == ST_EXEC) && (!r_out_v || i_pop)) r_out <= w_res;
    end

endmodule

// ----- rtl/core/hdic_checker.sv -----
// ----------------------------------------------------------------------------
// hdic_checker
// Port-level checks of the cache unit.
// ----------------------------------------------------------------------------
module hdic_checker import hdic_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_empty,
    input logic        i_pop,
    input logic        o_hit,
    input logic        o_next_valid,
    input logic [5:0]  o_hit_flags,
    input logic [31:0] o_hit_uses,
    input logic [31:0] o_hit_total
);

    // a held result stays valid and keeps its hit total
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_hit_total)))
        else $error("result changed while stalled");

    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_next_valid) |-> (o_hit && !o_hit_flags[FL_JUMP]))
        else $error("prediction without non-jump hit");

    a_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_hit) |-> (o_hit_uses == 32'd0 && o_hit_flags == 6'd0))
        else $error("miss with hit fields");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result after reset");

endmodule

bind hashed_decoded_instruction_cache_unit hdic_checker u_checker (
    .i_clk, .i_rst_n, .o_empty, .i_pop, .o_hit, .o_next_valid,
    .o_hit_flags, .o_hit_uses, .o_hit_total
);
